/* sv/reputation_norm_update_top_macros.svh */
// Assertion macros used by the reputation norm update controller.
`ifndef REPUTATION_NORM_UPDATE_TOP_MACROS_SVH
`define REPUTATION_NORM_UPDATE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define RNU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define RNU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RNU_ASSERT_NOW(lbl, ante, cons, msg)
`define RNU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/rnu_pkg.sv */
// Shared types, constants and norm logic for the reputation norm update block.
`default_nettype none
package rnu_pkg;

  localparam int MAX_AGENTS = 8;
  localparam int IDX_W      = $clog2(MAX_AGENTS);
  localparam int CNT_W      = 4;
  localparam int SUM_W      = 8;
  localparam int GOOD_W     = 7;

  localparam logic [1:0] RULE_L4 = 2'd0;
  localparam logic [1:0] RULE_L6 = 2'd1;
  localparam logic [1:0] RULE_L7 = 2'd2;
  localparam logic [1:0] RULE_L8 = 2'd3;

  localparam logic CFG_RULE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic [1:0]       RULE_RESET  = RULE_L7;
  localparam logic [CNT_W-1:0] COUNT_RESET = 4'd8;
  localparam logic [CNT_W-1:0] COUNT_MIN   = 4'd2;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 4'd8;

  typedef logic [MAX_AGENTS-1:0] row_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             latch;
    logic             load;
    logic             update;
    logic             sweep;
    logic [IDX_W-1:0] sweep_idx;
    logic             capture;
  } rnu_cmd_t;

  // New opinion of the donor held by one observer.
  function automatic logic norm_eval(input logic [1:0] rule, input logic od,
                                     input logic dr, input logic orr);
    logic res;
    begin
      case (rule)
        RULE_L4: res = dr ? (od | orr) : ~orr;
        RULE_L6: res = (orr == dr);
        RULE_L7: res = dr ? (od | orr) : (od & ~orr);
        RULE_L8: res = dr ? orr : (od & ~orr);
        default: res = 1'b0;
      endcase
      return res;
    end
  endfunction

  function automatic logic [CNT_W-1:0] popcount_row(input row_t v);
    logic [CNT_W-1:0] c;
    begin
      c = '0;
      for (int i = 0; i < MAX_AGENTS; i++) begin
        c = c + {{(CNT_W-1){1'b0}}, v[i]};
      end
      return c;
    end
  endfunction

endpackage
`default_nettype wire

/* sv/rnu_if.sv */
// Valid/ready channel interfaces for item beats and result beats.
`default_nettype none
interface rnu_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [2:0] load_row;
  logic [2:0] load_col;
  logic       load_value;
  logic [2:0] donor;
  logic [2:0] recipient;

  modport source (output valid, action, load_row, load_col, load_value, donor, recipient,
                  input ready);
  modport sink   (input valid, action, load_row, load_col, load_value, donor, recipient,
                  output ready);
endinterface

interface rnu_out_if;
  logic              valid;
  logic              ready;
  logic              absorbed;
  logic signed [7:0] opinion_sum;

  modport source (output valid, absorbed, opinion_sum, input ready);
  modport sink   (input valid, absorbed, opinion_sum, output ready);
endinterface
`default_nettype wire

/* sv/reputation_norm_update_top.sv */
// Top level of the reputation norm update block.
//
// Usage:
//   in_ch  : item beats (valid/ready). action 0 loads one opinion entry
//            (load_row, load_col, load_value); action 1 runs one norm step
//            for (donor, recipient) under the selected norm.
//   out_ch : one result beat per item: absorbed flag and opinion_sum.
//   cfg_*  : write-only registers, index 0 rule_select, index 1 agent_count.
//            Write only while the block is idle.
// Operation, with N active agents (agent_count clamped to 2..8):
//   an item runs from accept to result valid as the load or the column
//   update, then a sweep of the N donor rows, one donor row a cycle
//   (all observers and recipients checked in parallel, one row-read port on
//   the matrix), then a registered result. One item is in flight at
//   a time and the controller passes through idle before it takes the
//   next beat, so a new beat waits until the last result is captured.
// Reset: matrix all bad, rule_select L7, agent_count 8, no result pending.
// Stall: a waiting result sits in the output register; the next item is
//   still taken and runs, then holds its result until out_ch drains.
`default_nettype none
module reputation_norm_update_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  rnu_in_if.sink          in_ch,
  rnu_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_data
);

  logic [1:0]                  rule_r;
  logic [rnu_pkg::CNT_W-1:0]   count_r;
  logic [rnu_pkg::CNT_W-1:0]   n_active;
  rnu_pkg::rnu_cmd_t           cmd;

  // Configuration registers; index decode picks the target.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r  <= rnu_pkg::RULE_RESET;
      count_r <= rnu_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rnu_pkg::CFG_RULE:  rule_r  <= cfg_data[1:0];
        rnu_pkg::CFG_COUNT: count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the agent count into the supported range.
  always_comb begin
    if (count_r < rnu_pkg::COUNT_MIN) begin
      n_active = rnu_pkg::COUNT_MIN;
    end else if (count_r > rnu_pkg::COUNT_MAX) begin
      n_active = rnu_pkg::COUNT_MAX;
    end else begin
      n_active = count_r;
    end
  end

  rnu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .n_active  (n_active),
    .cmd       (cmd)
  );

  rnu_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .rule          (rule_r),
    .n_active      (n_active),
    .in_action     (in_ch.action),
    .in_load_row   (in_ch.load_row),
    .in_load_col   (in_ch.load_col),
    .in_load_value (in_ch.load_value),
    .in_donor      (in_ch.donor),
    .in_recipient  (in_ch.recipient),
    .res_absorbed  (out_ch.absorbed),
    .res_sum       (out_ch.opinion_sum)
  );

endmodule
`default_nettype wire

/* sv/rnu_ctrl.sv */
// Sequencer: accepts a beat, runs load/update, sweeps the donor rows, emits the result.
`default_nettype none
`include "reputation_norm_update_top_macros.svh"
module rnu_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_action,
  output logic                           in_ready,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  input  wire logic [rnu_pkg::CNT_W-1:0] n_active,
  output rnu_pkg::rnu_cmd_t              cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_SWEEP  = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [rnu_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        last_row;

  assign last_row  = ({1'b0, idx_r} == (n_active - rnu_pkg::CNT_W'(1)));
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = (in_action == rnu_pkg::ACT_STEP) ? ST_UPDATE : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        idx_nxt   = '0;
        state_nxt = ST_SWEEP;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        idx_nxt    = '0;
        state_nxt  = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.sweep     = 1'b1;
        cmd.sweep_idx = idx_r;
        if (last_row) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RNU_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready,
    state_r == ST_LOAD || state_r == ST_UPDATE, "accepted beat not dispatched")
  `RNU_ASSERT_NOW(a_sweep_in_range, state_r == ST_SWEEP,
    {1'b0, idx_r} < n_active, "sweep row beyond active agents")
  `RNU_ASSERT_NEXT(a_done_holds, state_r == ST_DONE && out_valid_r && !out_ready,
    state_r == ST_DONE && out_valid_r, "result dropped while output stalled")

endmodule
`default_nettype wire

/* sv/rnu_datapath.sv */
// Opinion matrix, norm evaluation array, absorbing check and opinion sum.
`default_nettype none
module rnu_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire rnu_pkg::rnu_cmd_t         cmd,
  input  wire logic [1:0]                rule,
  input  wire logic [rnu_pkg::CNT_W-1:0] n_active,
  input  wire logic                      in_action,
  input  wire logic [2:0]                in_load_row,
  input  wire logic [2:0]                in_load_col,
  input  wire logic                      in_load_value,
  input  wire logic [2:0]                in_donor,
  input  wire logic [2:0]                in_recipient,
  output logic                           res_absorbed,
  output logic signed [7:0]              res_sum
);

  rnu_pkg::row_t                     matrix_r [rnu_pkg::MAX_AGENTS];
  rnu_pkg::row_t                     matrix_nxt [rnu_pkg::MAX_AGENTS];
  logic                              act_r;
  logic [2:0]                        lrow_r, lcol_r, donor_r, recip_r;
  logic                              lval_r;
  logic                              absorb_r, absorb_nxt;
  logic [rnu_pkg::GOOD_W-1:0]        good_r, good_nxt;
  logic                              res_absorbed_r;
  logic signed [7:0]                 res_sum_r;

  rnu_pkg::row_t                     act_mask;
  logic [2:0]                        rd_addr;
  rnu_pkg::row_t                     rd_row;
  rnu_pkg::row_t                     fresh;
  logic                              step_ok;
  logic                              viol;
  logic [rnu_pkg::CNT_W-1:0]         pop;
  logic [7:0]                        nsq;
  logic signed [8:0]                 sum_w;
  logic signed [7:0]                 sum_sat;

  always_comb begin
    for (int i = 0; i < rnu_pkg::MAX_AGENTS; i++) begin
      act_mask[i] = (rnu_pkg::CNT_W'(i) < n_active);
    end
  end

  // One row read per cycle: the donor row during update, the swept row otherwise.
  assign rd_addr = cmd.update ? donor_r : cmd.sweep_idx;
  assign rd_row  = matrix_r[rd_addr];
  assign step_ok = act_mask[donor_r] & act_mask[recip_r];

  always_comb begin
    for (int o = 0; o < rnu_pkg::MAX_AGENTS; o++) begin
      fresh[o] = rnu_pkg::norm_eval(rule, matrix_r[o][donor_r], rd_row[recip_r],
                                    matrix_r[o][recip_r]);
    end
  end

  // Any active (observer, swept donor, recipient) triple whose norm disagrees.
  always_comb begin
    viol = 1'b0;
    for (int o = 0; o < rnu_pkg::MAX_AGENTS; o++) begin
      for (int r = 0; r < rnu_pkg::MAX_AGENTS; r++) begin
        if (act_mask[o] && act_mask[r] &&
            (rnu_pkg::norm_eval(rule, matrix_r[o][cmd.sweep_idx], rd_row[r],
                                matrix_r[o][r]) != matrix_r[o][cmd.sweep_idx])) begin
          viol = 1'b1;
        end
      end
    end
  end

  assign pop = rnu_pkg::popcount_row(rd_row & act_mask);

  always_comb begin
    for (int o = 0; o < rnu_pkg::MAX_AGENTS; o++) begin
      matrix_nxt[o] = matrix_r[o];
    end
    if (cmd.load) begin
      matrix_nxt[lrow_r][lcol_r] = lval_r;
    end
    if (cmd.update && step_ok) begin
      for (int o = 0; o < rnu_pkg::MAX_AGENTS; o++) begin
        if (act_mask[o]) begin
          matrix_nxt[o][donor_r] = fresh[o];
        end
      end
    end
  end

  always_comb begin
    absorb_nxt = absorb_r;
    good_nxt   = good_r;
    if (cmd.latch) begin
      absorb_nxt = 1'b1;
      good_nxt   = '0;
    end else if (cmd.sweep) begin
      absorb_nxt = absorb_r & ~viol;
      good_nxt   = good_r + {{(rnu_pkg::GOOD_W-rnu_pkg::CNT_W){1'b0}}, pop};
    end
  end

  assign nsq   = {4'b0, n_active} * {4'b0, n_active};
  assign sum_w = $signed({1'b0, good_r, 1'b0}) - $signed({1'b0, nsq});

  always_comb begin
    if (sum_w > 9'sd127) begin
      sum_sat = 8'sd127;
    end else if (sum_w < -9'sd128) begin
      sum_sat = -8'sd128;
    end else begin
      sum_sat = sum_w[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int o = 0; o < rnu_pkg::MAX_AGENTS; o++) begin
        matrix_r[o] <= '0;
      end
    end else begin
      for (int o = 0; o < rnu_pkg::MAX_AGENTS; o++) begin
        matrix_r[o] <= matrix_nxt[o];
      end
    end
  end

  always_ff @(posedge clk) begin
    absorb_r <= absorb_nxt;
    good_r   <= good_nxt;
    if (cmd.latch) begin
      act_r   <= in_action;
      lrow_r  <= in_load_row;
      lcol_r  <= in_load_col;
      lval_r  <= in_load_value;
      donor_r <= in_donor;
      recip_r <= in_recipient;
    end
    if (cmd.capture) begin
      res_absorbed_r <= (act_r == rnu_pkg::ACT_STEP) & absorb_r;
      res_sum_r      <= sum_sat;
    end
  end

  assign res_absorbed = res_absorbed_r;
  assign res_sum      = res_sum_r;

endmodule
`default_nettype wire

/* sim/reputation_norm_update_top_tb.sv */
// Self-checking testbench for the reputation norm update block.
module reputation_norm_update_top_tb;

  // Cycles without any beat before the run is declared hung. Slowest correct
  // gap is the long receiver hold-off (HOLD_CYCLES) plus item times.
  localparam int STALL_LIMIT   = 3000;
  // Leave margin after the last item before touching registers.
  localparam int SETTLE_CYCLES = rnu_pkg::MAX_AGENTS + 4;
  localparam int HOLD_CYCLES   = 150;

  typedef struct packed {
    logic       action;
    logic [2:0] load_row;
    logic [2:0] load_col;
    logic       load_value;
    logic [2:0] donor;
    logic [2:0] recipient;
  } opinion_item_t;

  typedef struct {
    logic              absorbed;
    logic signed [7:0] opinion_sum;
  } verdict_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [3:0] cfg_data;

  rnu_in_if  in_ch ();
  rnu_out_if out_ch ();

  reputation_norm_update_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block: opinion matrix plus both registers.
  rnu_pkg::row_t opinions [rnu_pkg::MAX_AGENTS];
  logic [1:0]    norm_cfg;
  logic [3:0]    agent_cfg;

  // Verdicts owed by the block, oldest first.
  verdict_t pending_verdicts [$];

  // Idle shaping, shared between the main flow and the result drain.
  int in_gap_max;
  int out_gap_max;
  int hold_request;

  int items_sent;
  int steps_sent;
  int loads_sent;
  int results_seen;
  int absorbed_seen;
  int error_count;
  int stall_count;

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Clamp the written agent count into the usable range.
  function automatic int live_agents();
    int n;
    n = int'(agent_cfg);
    if (n < 2) n = 2;
    if (n > rnu_pkg::MAX_AGENTS) n = rnu_pkg::MAX_AGENTS;
    return n;
  endfunction

  // Opinion an observer forms of the donor: od is its old view of the donor,
  // dr the donor's view of the recipient, orr its own view of the recipient.
  function automatic logic judged_good(input logic [1:0] norm, input logic od,
                                       input logic dr, input logic orr);
    case (norm)
      rnu_pkg::RULE_L4: return dr ? (od | orr) : !orr;
      rnu_pkg::RULE_L6: return orr == dr;
      rnu_pkg::RULE_L7: return dr ? (od | orr) : (od & !orr);
      default: return dr ? orr : (od & !orr);
    endcase
  endfunction

  // Absorbing: no active (observer, donor, recipient) triple moves an entry.
  function automatic logic is_stable(input int n);
    for (int o = 0; o < n; o++)
      for (int d = 0; d < n; d++)
        for (int r = 0; r < n; r++)
          if (judged_good(norm_cfg, opinions[o][d], opinions[d][r], opinions[o][r])
              != opinions[o][d])
            return 1'b0;
    return 1'b1;
  endfunction

  // Sum of active entries as +1 / -1, saturated to the 8-bit field.
  function automatic logic signed [7:0] tally(input int n);
    int good;
    int s;
    good = 0;
    for (int o = 0; o < n; o++)
      for (int t = 0; t < n; t++)
        if (opinions[o][t]) good++;
    s = 2 * good - n * n;
    if (s > 127) s = 127;
    if (s < -128) s = -128;
    return s[7:0];
  endfunction

  // Apply one accepted item to the shadow state and return its verdict.
  function automatic verdict_t predict_verdict(input opinion_item_t it);
    int       n;
    logic     fresh [rnu_pkg::MAX_AGENTS];
    verdict_t v;
    n = live_agents();
    v.absorbed = 1'b0;
    if (it.action == rnu_pkg::ACT_LOAD) begin
      opinions[it.load_row][it.load_col] = it.load_value;
    end else begin
      // Inactive donor or recipient: leave the matrix, still report.
      if (it.donor < n && it.recipient < n) begin
        for (int o = 0; o < n; o++)
          fresh[o] = judged_good(norm_cfg, opinions[o][it.donor],
                                 opinions[it.donor][it.recipient],
                                 opinions[o][it.recipient]);
        for (int o = 0; o < n; o++) opinions[o][it.donor] = fresh[o];
      end
      v.absorbed = is_stable(n);
    end
    v.opinion_sum = tally(n);
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, watchdog, result drain and checking
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles with no beat on either channel; end the run if hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_count <= 0;
      else
        stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("reputation_norm_update_top_tb: done, errors");
        $finish;
      end
    end
  end

  // Drain results: per beat, hold ready low for a drawn number of cycles,
  // or for the long hold-off when one is requested.
  initial begin : result_drain
    int wait_cycles;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        wait_cycles  = hold_request;
        hold_request = 0;
      end else begin
        wait_cycles = $urandom_range(0, out_gap_max);
      end
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare every result beat with the oldest owed verdict.
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (out_ch.absorbed) absorbed_seen <= absorbed_seen + 1;
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no verdict owed: absorbed %0b, opinion_sum %0d",
               out_ch.absorbed, out_ch.opinion_sum);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.absorbed !== want.absorbed) begin
          $error("absorbed: expected %0b, got %0b", want.absorbed, out_ch.absorbed);
          error_count++;
        end
        if (out_ch.opinion_sum !== want.opinion_sum) begin
          $error("opinion_sum: expected %0d, got %0d", want.opinion_sum,
                 out_ch.opinion_sum);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Offer one item after a drawn gap; hold it until the beat is taken.
  // Valid stays high afterwards so a zero gap offers the next item at once.
  task automatic offer_item(input opinion_item_t it);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= it.action;
    in_ch.load_row   <= it.load_row;
    in_ch.load_col   <= it.load_col;
    in_ch.load_value <= it.load_value;
    in_ch.donor      <= it.donor;
    in_ch.recipient  <= it.recipient;
    do @(posedge clk); while (!in_ch.ready);
    pending_verdicts.insert(pending_verdicts.size(), predict_verdict(it));
    items_sent++;
    if (it.action == rnu_pkg::ACT_STEP) steps_sent++;
    else loads_sent++;
  endtask

  // Fields the action does not use carry random junk.
  task automatic load_entry(input int row, input int col, input logic value);
    logic [13:0]   raw;
    opinion_item_t it;
    raw = 14'($urandom);
    it = raw;
    it.action     = rnu_pkg::ACT_LOAD;
    it.load_row   = row[2:0];
    it.load_col   = col[2:0];
    it.load_value = value;
    offer_item(it);
  endtask

  task automatic step_pair(input int donor, input int recipient);
    logic [13:0]   raw;
    opinion_item_t it;
    raw = 14'($urandom);
    it = raw;
    it.action    = rnu_pkg::ACT_STEP;
    it.donor     = donor[2:0];
    it.recipient = recipient[2:0];
    offer_item(it);
  endtask

  // Drop valid and wait until every owed verdict is in, then let the block
  // finish any internal work.
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [3:0] value);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rnu_pkg::CFG_RULE) norm_cfg = value[1:0];
    else agent_cfg = value;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // All-bad matrix under the reset norm, all eight agents.
  task automatic test_reset_matrix();
    step_pair(0, 7);
    step_pair(7, 0);
  endtask

  // Corner entries of the store, both values.
  task automatic test_load_corners();
    load_entry(0, 0, 1'b1);
    load_entry(0, 7, 1'b1);
    load_entry(7, 0, 1'b0);
    load_entry(7, 7, 1'b0);
  endtask

  // Count below the minimum clamps to two; inactive entries are kept and
  // show up once the count grows; steps on inactive agents change nothing.
  task automatic test_inactive_agents();
    write_register(rnu_pkg::CFG_COUNT, 4'd0);
    load_entry(5, 6, 1'b1);
    step_pair(5, 0);
    step_pair(0, 7);
    step_pair(1, 0);
    write_register(rnu_pkg::CFG_COUNT, 4'd15);
    step_pair(6, 5);
    write_register(rnu_pkg::CFG_COUNT, 4'd1);
    step_pair(0, 1);
  endtask

  // Each norm with a good and a bad donor-to-recipient view.
  task automatic test_each_norm();
    logic [1:0] norms [4];
    norms = '{rnu_pkg::RULE_L4, rnu_pkg::RULE_L6, rnu_pkg::RULE_L7, rnu_pkg::RULE_L8};
    write_register(rnu_pkg::CFG_COUNT, 4'd3);
    load_entry(1, 2, 1'b1);
    load_entry(2, 0, 1'b0);
    foreach (norms[i]) begin
      write_register(rnu_pkg::CFG_RULE, {2'b00, norms[i]});
      step_pair(1, 2);
      step_pair(2, 0);
    end
  endtask

  // Hold the result side off while items keep coming, so the block fills
  // and stalls its input; then pause the sender until all results are in.
  task automatic test_backpressure();
    write_register(rnu_pkg::CFG_COUNT, 4'd8);
    in_gap_max   = 0;
    out_gap_max  = 13;
    hold_request = HOLD_CYCLES;
    repeat (16) step_pair($urandom_range(0, 7), $urandom_range(0, 7));
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    in_gap_max = 13;
    repeat (8) step_pair($urandom_range(0, 7), $urandom_range(0, 7));
  endtask

  // Phases over every norm and a spread of counts, extremes included.
  // Most items are steps on active agents; the rest are loads, a few aimed
  // outside the active block, and steps on any of the eight agent indices.
  task automatic test_random_phases();
    int         phase_counts [12] = '{2, 8, 3, 0, 5, 15, 4, 1, 6, 9, 7, 8};
    int         n;
    int         pick;
    int         row;
    int         col;
    logic       fill_value;
    logic [1:0] norm;
    for (int p = 0; p < 12; p++) begin
      norm = p[1:0];
      case (p % 4)
        1: begin
          in_gap_max  = 0;
          out_gap_max = 0;
        end
        3: begin
          in_gap_max  = 0;
          out_gap_max = 13;
        end
        default: begin
          in_gap_max  = 13;
          out_gap_max = 13;
        end
      endcase
      // Upper bits of the norm write are don't-care; vary them.
      write_register(rnu_pkg::CFG_RULE, {2'($urandom_range(0, 3)), norm});
      write_register(rnu_pkg::CFG_COUNT, 4'(phase_counts[p]));
      n = live_agents();
      // Uniform small matrices tend to sit at or near absorbing states.
      if (n <= 4 && $urandom_range(0, 1) == 0) begin
        fill_value = 1'($urandom_range(0, 1));
        for (int o = 0; o < n; o++)
          for (int t = 0; t < n; t++) load_entry(o, t, fill_value);
      end
      repeat (88) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          if ($urandom_range(0, 9) == 0) begin
            row = $urandom_range(0, 7);
            col = $urandom_range(0, 7);
          end else begin
            row = $urandom_range(0, n - 1);
            col = $urandom_range(0, n - 1);
          end
          load_entry(row, col, 1'($urandom_range(0, 1)));
        end else if (pick < 92) begin
          step_pair($urandom_range(0, n - 1), $urandom_range(0, n - 1));
        end else begin
          step_pair($urandom_range(0, 7), $urandom_range(0, 7));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main flow
  // ---------------------------------------------------------------------

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = rnu_pkg::CFG_RULE;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.action     = rnu_pkg::ACT_LOAD;
    in_ch.load_row   = '0;
    in_ch.load_col   = '0;
    in_ch.load_value = 1'b0;
    in_ch.donor      = '0;
    in_ch.recipient  = '0;
    out_ch.ready     = 1'b0;
    in_gap_max       = 13;
    out_gap_max      = 13;
    hold_request     = 0;
    items_sent       = 0;
    steps_sent       = 0;
    loads_sent       = 0;
    results_seen     = 0;
    absorbed_seen    = 0;
    error_count      = 0;
    stall_count      = 0;
    foreach (opinions[i]) opinions[i] = '0;
    norm_cfg  = rnu_pkg::RULE_RESET;
    agent_cfg = rnu_pkg::COUNT_RESET;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_matrix();
    test_load_corners();
    test_inactive_agents();
    test_each_norm();
    test_backpressure();
    test_random_phases();

    // Wait out the last results, then SETTLE_CYCLES for stray beats.
    settle_idle();

    $display("covered %0d items (%0d steps, %0d loads) over all four norms",
             items_sent, steps_sent, loads_sent);
    $display("checked %0d results, %0d of them absorbing", results_seen, absorbed_seen);
    if (error_count == 0) begin
      $display("reputation_norm_update_top_tb: done, clean");
    end else begin
      $display("reputation_norm_update_top_tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/rnu_pkg.sv
sv/rnu_if.sv
sv/rnu_ctrl.sv
sv/rnu_datapath.sv
sv/reputation_norm_update_top.sv
sim/reputation_norm_update_top_tb.sv
